### src/bfd_pkg.sv
// Package with shared types, constants and helpers for the block float divider.
package bfd_pkg;

  localparam int unsigned MANT_W = 32;
  localparam int unsigned QUO_W  = MANT_W + 1;
  localparam int unsigned SH_W   = 36;
  localparam int unsigned RES_W  = 64;
  localparam int unsigned Q_W    = 7;
  localparam int unsigned LZ_W   = 6;
  localparam int unsigned NCELLS = QUO_W;
  localparam int unsigned SHA_W  = 6;

  localparam logic [1:0] REG_Q_FORMAT = 2'd0;

  typedef struct packed {
    logic [MANT_W-1:0]       rem;
    logic [MANT_W-1:0]       dvs;
    logic                    lsb;
    logic [QUO_W-1:0]        quo;
    logic signed [SH_W-1:0]  sh;
    logic                    az;
    logic                    dz;
  } stage_t;

  typedef struct packed {
    logic en;
  } ctl_t;

  function automatic logic [LZ_W-1:0] lead_zeros(input logic [MANT_W-1:0] x);
    logic [LZ_W-1:0] n;
    logic            found;
    n = LZ_W'(MANT_W);
    found = 1'b0;
    for (int i = MANT_W - 1; i >= 0; i--) begin
      if (!found && x[i]) begin
        n = LZ_W'(MANT_W - 1 - i);
        found = 1'b1;
      end
    end
    return n;
  endfunction

endpackage

### src/bfd_if.sv
// Valid/ready channel interfaces for requests and results.
interface bfd_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] dividend_mant;
  logic signed [31:0] num_exp;
  logic [31:0] divisor_mant;
  logic signed [31:0] den_exp;
  modport source (output valid, dividend_mant, num_exp, divisor_mant, den_exp,
                  input ready);
  modport sink (input valid, dividend_mant, num_exp, divisor_mant, den_exp,
                output ready);
endinterface

interface bfd_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] fixed_quotient;
  logic        overflow;
  logic        divide_by_zero;
  modport source (output valid, fixed_quotient, overflow, divide_by_zero, input ready);
  modport sink (input valid, fixed_quotient, overflow, divide_by_zero, output ready);
endinterface

### src/bfd_norm.sv
// Front stage: normalizes both mantissas and forms the final shift amount.
module bfd_norm (
  input  logic                            clk,
  input  logic                            rst,
  input  bfd_pkg::ctl_t                   ctl,
  input  logic                            in_v,
  input  logic [bfd_pkg::MANT_W-1:0]      a,
  input  logic signed [31:0]              ae,
  input  logic [bfd_pkg::MANT_W-1:0]      b,
  input  logic signed [31:0]              be,
  input  logic signed [bfd_pkg::Q_W-1:0]  qfmt,
  output logic                            out_v,
  output bfd_pkg::stage_t                 out_s
);
  logic [bfd_pkg::LZ_W-1:0]   la, lb;
  logic [bfd_pkg::MANT_W-1:0] na, nb;
  bfd_pkg::stage_t            s_next;

  always_comb begin
    la = bfd_pkg::lead_zeros(a);
    lb = bfd_pkg::lead_zeros(b);
    na = a << la;
    nb = b << lb;
    s_next.rem = {1'b0, na[bfd_pkg::MANT_W-1:1]};
    s_next.lsb = na[0];
    s_next.dvs = nb;
    s_next.quo = '0;
    // Left shift of raw quotient: normalized exponent gap - 32 + Q format.
    s_next.sh  = bfd_pkg::SH_W'(ae) - bfd_pkg::SH_W'(la) - bfd_pkg::SH_W'(be)
               + bfd_pkg::SH_W'(lb) - bfd_pkg::SH_W'(32) + bfd_pkg::SH_W'(qfmt);
    s_next.az  = (a == '0);
    s_next.dz  = (b == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (ctl.en) begin
      out_v <= in_v;
    end
    if (ctl.en) begin
      out_s <= s_next;
    end
  end
endmodule

### src/bfd_cell.sv
// One restoring division cell: produces one quotient bit per item.
module bfd_cell (
  input  logic            clk,
  input  logic            rst,
  input  bfd_pkg::ctl_t   ctl,
  input  logic            in_v,
  input  bfd_pkg::stage_t in_s,
  output logic            out_v,
  output bfd_pkg::stage_t out_s
);
  logic [bfd_pkg::MANT_W:0] t;
  logic                     ge;
  bfd_pkg::stage_t          s_next;

  always_comb begin
    t  = {in_s.rem, in_s.lsb};
    ge = (t >= {1'b0, in_s.dvs});
    s_next     = in_s;
    s_next.rem = ge ? bfd_pkg::MANT_W'(t - {1'b0, in_s.dvs}) : t[bfd_pkg::MANT_W-1:0];
    s_next.lsb = 1'b0;
    s_next.quo = {in_s.quo[bfd_pkg::QUO_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (ctl.en) begin
      out_v <= in_v;
    end
    if (ctl.en) begin
      out_s <= s_next;
    end
  end
endmodule

### src/bfd_fmt.sv
// Output stage: shifts the quotient into Q format, rounds and saturates.
module bfd_fmt (
  input  logic                       clk,
  input  logic                       rst,
  input  bfd_pkg::ctl_t              ctl,
  input  logic                       in_v,
  input  bfd_pkg::stage_t            in_s,
  output logic                       out_v,
  output logic [bfd_pkg::RES_W-1:0]  res,
  output logic                       ovf,
  output logic                       dz
);
  logic [bfd_pkg::SH_W-1:0]            rsh;
  logic [bfd_pkg::QUO_W:0]             rx;
  logic [bfd_pkg::RES_W+bfd_pkg::QUO_W-1:0] lx;
  logic [bfd_pkg::RES_W-1:0]           res_next;
  logic                                ovf_next;

  always_comb begin
    rsh = bfd_pkg::SH_W'(-in_s.sh);
    rx  = {in_s.quo, 1'b0} >> rsh[bfd_pkg::SHA_W-1:0];
    lx  = {{bfd_pkg::RES_W{1'b0}}, in_s.quo} << in_s.sh[bfd_pkg::SHA_W-1:0];
    res_next = '0;
    ovf_next = 1'b0;
    if (in_s.dz) begin
      res_next = '1;
    end else if (in_s.az) begin
      res_next = '0;
    end else if (in_s.sh < 0) begin
      if (rsh >= bfd_pkg::SH_W'(bfd_pkg::RES_W)) begin
        res_next = '0;
      end else begin
        res_next = bfd_pkg::RES_W'(rx[bfd_pkg::QUO_W:1]) + bfd_pkg::RES_W'(rx[0]);
      end
    end else if (in_s.sh >= bfd_pkg::SH_W'(bfd_pkg::RES_W) ||
                 lx[bfd_pkg::RES_W+bfd_pkg::QUO_W-1:bfd_pkg::RES_W] != '0) begin
      res_next = '1;
      ovf_next = 1'b1;
    end else begin
      res_next = lx[bfd_pkg::RES_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (ctl.en) begin
      out_v <= in_v;
    end
    if (ctl.en) begin
      res <= res_next;
      ovf <= ovf_next;
      dz  <= in_s.dz;
    end
  end
endmodule

### src/block_float_divide_to_fixed_q.sv
// Block floating-point divider that returns a fixed-point quotient in a set Q format.
// One request is taken per cycle while no result is held, and it passes through
// one normalizing stage, a row of 33 restoring-division cells that each decide one
// quotient bit, and one stage that shifts, rounds and saturates into the output
// register. A held result stalls the whole row and the input together, so no new
// request is taken while a result waits to be accepted.
module block_float_divide_to_fixed_q (
  input  logic               clk,
  input  logic               rst,
  bfd_in_if.sink             din,
  bfd_out_if.source          dout,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [1:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  logic signed [bfd_pkg::Q_W-1:0] qfmt;
  bfd_pkg::ctl_t                  ctl;
  logic            v   [bfd_pkg::NCELLS+1];
  bfd_pkg::stage_t s   [bfd_pkg::NCELLS+1];

  assign pready = 1'b1;
  assign prdata = 32'(qfmt);

  always_ff @(posedge clk) begin
    if (rst) begin
      qfmt <= '0;
    end else if (psel && penable && pwrite && paddr == bfd_pkg::REG_Q_FORMAT) begin
      qfmt <= pwdata[bfd_pkg::Q_W-1:0];
    end
  end

  assign ctl.en    = !(dout.valid && !dout.ready);
  assign din.ready = ctl.en;

  bfd_norm u_norm (
    .clk, .rst, .ctl, .in_v(din.valid),
    .a(din.dividend_mant), .ae(din.num_exp),
    .b(din.divisor_mant), .be(din.den_exp), .qfmt,
    .out_v(v[0]), .out_s(s[0])
  );

  for (genvar i = 0; i < bfd_pkg::NCELLS; i++) begin : g_cell
    bfd_cell u_cell (
      .clk, .rst, .ctl, .in_v(v[i]), .in_s(s[i]), .out_v(v[i+1]), .out_s(s[i+1])
    );
  end

  bfd_fmt u_fmt (
    .clk, .rst, .ctl, .in_v(v[bfd_pkg::NCELLS]), .in_s(s[bfd_pkg::NCELLS]),
    .out_v(dout.valid), .res(dout.fixed_quotient), .ovf(dout.overflow),
    .dz(dout.divide_by_zero)
  );

  a_dz_ones: assert property (@(posedge clk) disable iff (rst)
    dout.valid && dout.divide_by_zero |-> dout.fixed_quotient == '1 && !dout.overflow)
    else $error("divide by zero result not saturated");
  a_ovf_ones: assert property (@(posedge clk) disable iff (rst)
    dout.valid && dout.overflow |-> dout.fixed_quotient == '1)
    else $error("overflow result not saturated");
  a_stall: assert property (@(posedge clk) disable iff (rst)
    dout.valid && !dout.ready |-> !din.ready)
    else $error("request taken while row stalled");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    dout.valid && !dout.ready |=> dout.valid && $stable(dout.fixed_quotient))
    else $error("held result changed");
endmodule
